// File: src/lpct_pkg.sv
package lpct_pkg;

   localparam int PAGE_W = 16;
   localparam int SLOT_W = 4;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              evicted;
      logic [PAGE_W-1:0] evicted_page_id;
   } lpct_rsp_type;

endpackage

// File: src/lpct_tag_store.sv
module lpct_tag_store import lpct_pkg::*; #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               lookup_en,
   input  logic [PAGE_W-1:0]  page_id,
   input  logic [CAP_W-1:0]   capacity,
   output lpct_rsp_type       rsp
);

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);

   logic [KEY_BITS-1:0] key_ff [ENTRIES];
   logic [KEY_BITS-1:0] key_in [ENTRIES];
   logic [ENTRIES-1:0]  key_we;
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [IDX_BITS-1:0] rank_ff [ENTRIES];
   logic [IDX_BITS-1:0] rank_in [ENTRIES];
   logic [CNT_BITS-1:0] fill_ff, fill_in;

   logic [KEY_BITS-1:0] key;
   logic [CNT_BITS-1:0] cap_eff;
   logic [CNT_BITS-1:0] last_rank;
   logic [ENTRIES-1:0]  match, victim, bump;
   logic                hit_any, free_any, victim_any, has_room;
   logic [IDX_BITS-1:0] hit_idx, free_idx, victim_idx, slot_idx;
   logic [IDX_BITS-1:0] hit_rank;
   logic                do_fill, do_evict, do_patch;

   assign key = KEY_BITS'(page_id);

   always_comb begin
      if (capacity == '0) begin
         cap_eff = CNT_BITS'(1);
      end else if (int'(capacity) > ENTRIES) begin
         cap_eff = CNT_BITS'(ENTRIES);
      end else begin
         cap_eff = CNT_BITS'(capacity);
      end
   end

   assign last_rank = fill_ff - CNT_BITS'(1);
   assign has_room  = fill_ff < cap_eff;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (key_ff[i] == key);
         victim[i] = valid_ff[i] && (CNT_BITS'(rank_ff[i]) == last_rank);
      end
   end

   always_comb begin
      hit_any    = 1'b0;
      hit_idx    = '0;
      free_any   = 1'b0;
      free_idx   = '0;
      victim_any = 1'b0;
      victim_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_any = 1'b1;
            hit_idx = IDX_BITS'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_BITS'(i);
         end
         if (victim[i]) begin
            victim_any = 1'b1;
            victim_idx = IDX_BITS'(i);
         end
      end
   end

   assign hit_rank = rank_ff[hit_idx];
   assign do_fill  = !hit_any && has_room;
   assign do_evict = !hit_any && !has_room && victim_any;
   assign do_patch = !hit_any && !has_room && !victim_any;

   always_comb begin
      if (hit_any) begin
         slot_idx = hit_idx;
      end else if (do_fill) begin
         slot_idx = free_any ? free_idx : '0;
      end else if (do_evict) begin
         slot_idx = victim_idx;
      end else begin
         slot_idx = '0;
      end
   end

   always_comb begin
      rsp.hit             = hit_any;
      rsp.slot            = SLOT_W'(slot_idx);
      rsp.evicted         = do_evict;
      rsp.evicted_page_id = do_evict ? PAGE_W'(key_ff[victim_idx]) : '0;
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         bump[i]    = valid_ff[i] && (slot_idx != IDX_BITS'(i))
                      && (!hit_any || (rank_ff[i] < hit_rank));
         key_we[i]  = lookup_en && (slot_idx == IDX_BITS'(i));
         key_in[i]  = key;
         valid_in[i] = valid_ff[i] || key_we[i];
         if (key_we[i]) begin
            rank_in[i] = '0;
         end else if (lookup_en && bump[i]) begin
            rank_in[i] = rank_ff[i] + IDX_BITS'(1);
         end else begin
            rank_in[i] = rank_ff[i];
         end
      end
      if (lookup_en && do_fill) begin
         fill_in = fill_ff + CNT_BITS'(1);
      end else if (lookup_en && do_patch && fill_ff == '0) begin
         fill_in = CNT_BITS'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
         fill_ff  <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         fill_ff  <= fill_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (key_we[i]) begin
            key_ff[i] <= key_in[i];
         end
      end
   end

endmodule

// File: src/lru_page_cache_tags.sv
// channel  | direction | payload                                    | handshake
// req      | in        | page_id                                    | req_valid / req_ready
// rsp      | out       | hit, slot, evicted, evicted_page_id        | rsp_valid / rsp_ready
// csr      | in        | capacity                                   | csr_write_en, no wait
//
// One request per cycle while rsp_ready is high; request and response are registered.
// The throughput is set by the combinational tag compare and rank update over all entries.
// Synchronous reset empties the store and sets capacity to 10.
// A capacity write empties the store in the same cycle.
// A stalled response holds; the request register still takes one more request behind it.
module lru_page_cache_tags import lpct_pkg::*; #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [PAGE_W-1:0] req_page_id,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_hit,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic              rsp_evicted,
   output logic [PAGE_W-1:0] rsp_evicted_page_id,
   input  logic              csr_write_en,
   input  logic [CAP_W-1:0]  csr_write_data
);

   logic              req_vld_ff, req_vld_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic              rsp_vld_ff, rsp_vld_in;
   lpct_rsp_type      rsp_ff, rsp_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   lpct_rsp_type      store_rsp;
   logic              advance, req_take;

   assign advance   = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      req_vld_in = req_take || (req_vld_ff && !advance);
      page_in    = req_take ? req_page_id : page_ff;
      rsp_vld_in = advance || (rsp_vld_ff && !rsp_ready);
      rsp_in     = advance ? store_rsp : rsp_ff;
      cap_in     = csr_write_en ? csr_write_data : cap_ff;
   end

   lpct_tag_store #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .clear     (csr_write_en),
      .lookup_en (advance),
      .page_id   (page_ff),
      .capacity  (cap_ff),
      .rsp       (store_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         cap_ff     <= CAP_RESET;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         cap_ff     <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_hit             = rsp_ff.hit;
   assign rsp_slot            = rsp_ff.slot;
   assign rsp_evicted         = rsp_ff.evicted;
   assign rsp_evicted_page_id = rsp_ff.evicted_page_id;

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(rsp_ff.hit && rsp_ff.evicted))
      else $error("response reports both hit and eviction");

   a_evict_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ff.evicted) |-> (rsp_ff.evicted_page_id == '0))
      else $error("evicted page id set without eviction");

   a_repeat_hits: assert property (@(posedge clock) disable iff (reset)
      (advance && $past(advance) && !$past(reset) && !$past(csr_write_en)
         && (page_ff == $past(page_ff)))
      |-> (store_rsp.hit && (store_rsp.slot == $past(store_rsp.slot))))
      else $error("repeated page missed the entry just written");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("lookup result lost");

endmodule
